// ===== sv/cfc_pkg.sv =====
// shared types, constants and crc function for the command frame checker
package cfc_pkg;

    // frame layout
    localparam int FRAME_BYTES = 16;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CRC_END_POS = POS_W'(14);
    localparam logic [POS_W-1:0] HEAD_POS    = POS_W'(0);
    localparam logic [POS_W-1:0] CMD_POS     = POS_W'(1);
    localparam logic [POS_W-1:0] VAL_POS     = POS_W'(2);

    localparam int NUM_VALUES = 6;
    localparam int VIDX_W     = $clog2(NUM_VALUES);

    // command codes
    localparam logic [7:0] CMD_JOINT = 8'h00;
    localparam logic [7:0] CMD_POSE  = 8'h01;
    localparam logic [7:0] CMD_STOP  = 8'hFF;

    // crc-16, msb first
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration registers
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED   = CFG_IDX_W'(1);
    localparam logic [7:0]  EXP_HEADER_RST = 8'hAA;
    localparam logic [15:0] CRC_SEED_RST   = 16'hFFFF;

    // queue depths
    localparam int MID_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    // byte role within a frame
    typedef enum logic [2:0] {
        K_HEAD,
        K_CMD,
        K_VAL_HI,
        K_VAL_LO,
        K_CRC_HI,
        K_CRC_LO
    } t_kind;

    typedef enum logic [2:0] {
        ACT_CRC_ERR = 3'd0,
        ACT_JOINT   = 3'd1,
        ACT_POSE    = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_UNKNOWN = 3'd4
    } t_action;

    // classified byte passed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [VIDX_W-1:0] vidx;
        logic              hdr_match;
        logic [7:0]        data;
    } t_mid;

    // one frame result
    typedef struct packed {
        logic                        header_ok;
        logic                        crc_ok;
        t_action                     action;
        logic [NUM_VALUES-1:0][15:0] values;
    } t_res;

    // feed one byte into the crc register
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== sv/cfc_fifo.sv =====
// small register-based queue used between the stages and at the output
module cfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count over depth");

endmodule

// ===== sv/cfc_front.sv =====
// front stage: byte position counting and byte classification
module cfc_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [7:0]   i_frame_byte,
    output logic         o_full,
    input  logic [7:0]   i_exp_header,
    input  logic         i_mid_full,
    output logic         o_mid_push,
    output cfc_pkg::t_mid o_mid_item
);
    import cfc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             accept;
    logic [POS_W-1:0] val_off;

    assign o_full     = i_mid_full;
    assign accept     = i_push && !i_mid_full;
    assign o_mid_push = accept;
    assign val_off    = r_pos - VAL_POS;

    // classify the byte by its place in the frame
    always_comb begin
        o_mid_item.data      = i_frame_byte;
        o_mid_item.hdr_match = (i_frame_byte == i_exp_header);
        o_mid_item.vidx      = VIDX_W'(val_off >> 1);
        if (r_pos == HEAD_POS) begin
            o_mid_item.kind = K_HEAD;
        end else if (r_pos == CMD_POS) begin
            o_mid_item.kind = K_CMD;
        end else if (r_pos < CRC_END_POS) begin
            o_mid_item.kind = r_pos[0] ? K_VAL_LO : K_VAL_HI;
        end else if (r_pos == CRC_END_POS) begin
            o_mid_item.kind = K_CRC_HI;
        end else begin
            o_mid_item.kind = K_CRC_LO;
        end
    end

    // position counter, wraps at the frame end
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // a frame always closes with the low crc byte
    a_last_is_crc_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_pos == LAST_POS) |-> (o_mid_item.kind == K_CRC_LO))
        else $error("frame end not tagged as crc low byte");

endmodule

// ===== sv/cfc_back.sv =====
// back stage: crc update, value capture and result building
module cfc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_crc_seed,
    input  logic          i_mid_empty,
    input  cfc_pkg::t_mid i_mid_item,
    output logic          o_mid_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output cfc_pkg::t_res o_res
);
    import cfc_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic        r_hdr_ok;
    logic [7:0]  r_cmd;
    logic [7:0]  r_crc_hi;
    logic [15:0] r_val [NUM_VALUES];
    logic        take;
    logic        good;
    logic [15:0] crc_in;

    // stall only a frame end that has nowhere to go
    assign o_mid_pop  = !i_mid_empty && (i_mid_item.kind != K_CRC_LO || !i_res_full);
    assign take       = o_mid_pop;
    assign o_res_push = take && i_mid_item.kind == K_CRC_LO;

    // crc runs over every byte before the crc field
    assign crc_in = (i_mid_item.kind == K_HEAD) ? i_crc_seed : r_crc;
    always_comb begin
        n_crc = r_crc;
        if (take && i_mid_item.kind != K_CRC_HI && i_mid_item.kind != K_CRC_LO) begin
            n_crc = crc_feed(crc_in, i_mid_item.data);
        end
    end

    // result fields
    assign good = ({r_crc_hi, i_mid_item.data} == r_crc);
    always_comb begin
        o_res.header_ok = r_hdr_ok;
        o_res.crc_ok    = good;
        if (r_cmd == CMD_STOP) begin
            o_res.action = ACT_STOP;
        end else if (!good) begin
            o_res.action = ACT_CRC_ERR;
        end else if (r_cmd == CMD_JOINT) begin
            o_res.action = ACT_JOINT;
        end else if (r_cmd == CMD_POSE) begin
            o_res.action = ACT_POSE;
        end else begin
            o_res.action = ACT_UNKNOWN;
        end
        for (int i = 0; i < NUM_VALUES; i++) begin
            o_res.values[i] = r_val[i];
        end
    end

    // frame control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_SEED_RST;
            r_hdr_ok <= 1'b0;
            r_cmd    <= '0;
            r_crc_hi <= '0;
        end else begin
            r_crc <= n_crc;
            if (take) begin
                case (i_mid_item.kind)
                    K_HEAD:   r_hdr_ok <= i_mid_item.hdr_match;
                    K_CMD:    r_cmd    <= i_mid_item.data;
                    K_CRC_HI: r_crc_hi <= i_mid_item.data;
                    default: ;
                endcase
            end
        end
    end

    // value store, big-endian halves
    always_ff @(posedge i_clk) begin
        if (take && i_mid_item.kind == K_VAL_HI) begin
            r_val[i_mid_item.vidx][15:8] <= i_mid_item.data;
        end
        if (take && i_mid_item.kind == K_VAL_LO) begin
            r_val[i_mid_item.vidx][7:0] <= i_mid_item.data;
        end
    end

    // stop wins over a crc failure
    a_stop_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> ((r_cmd == CMD_STOP) == (o_res.action == ACT_STOP)))
        else $error("stop command not reported as stop");

    // a bad crc on other commands gives the crc error action
    a_crc_err_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && !o_res.crc_ok && r_cmd != CMD_STOP) |-> (o_res.action == ACT_CRC_ERR))
        else $error("bad crc not flagged");

endmodule

// ===== sv/command_frame_checker.sv =====
// top level of the command frame checker
//
// Byte input is a queue write port: a beat is taken when i_push is high and
// o_full is low. Every 16 bytes, counted from reset, form one frame: header,
// command, six big-endian signed 16-bit values, crc-16 high then low byte.
// Results come out as a queue read port: while o_empty is low the oldest
// frame result is on the o_ ports, and it is taken when i_pop is high.
// One result per frame, none for the other 15 bytes.
// Throughput is one byte per cycle while o_full is low; the crc unit folds a
// whole byte per cycle. A result passes the byte queue and then the result
// queue, both registered; the back stage itself is combinational.
// Configuration (expected header, crc seed) is written through i_cfg_valid /
// o_cfg_ready, always ready, and should be changed only while the block is idle.
// Reset clears the byte position and both queues and loads the register defaults.
// If the receiver stops popping, the result queue fills, the back stage holds
// the next frame's last byte, the byte queue fills and o_full goes high.
module command_frame_checker #(
    parameter int MID_DEPTH = cfc_pkg::MID_DEPTH_DEF,
    parameter int RES_DEPTH = cfc_pkg::RES_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [7:0]                    i_frame_byte,
    output logic                          o_full,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_header_ok,
    output logic                          o_crc_ok,
    output logic [2:0]                    o_action,
    output logic signed [15:0]            o_value_a,
    output logic signed [15:0]            o_value_b,
    output logic signed [15:0]            o_value_c,
    output logic signed [15:0]            o_value_d,
    output logic signed [15:0]            o_value_e,
    output logic signed [15:0]            o_value_f,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import cfc_pkg::*;

    logic [7:0]  r_exp_header;
    logic [15:0] r_crc_seed;

    logic        mid_push, mid_full, mid_pop, mid_empty;
    t_mid        mid_in, mid_out;
    logic        res_push, res_full;
    t_res        res_in, res_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_header <= EXP_HEADER_RST;
            r_crc_seed   <= CRC_SEED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_EXP_HEADER) begin
                r_exp_header <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_CRC_SEED) begin
                r_crc_seed <= i_cfg_data;
            end
        end
    end

    cfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_frame_byte (i_frame_byte),
        .o_full       (o_full),
        .i_exp_header (r_exp_header),
        .i_mid_full   (mid_full),
        .o_mid_push   (mid_push),
        .o_mid_item   (mid_in)
    );

    // classified byte queue
    cfc_fifo #(
        .WIDTH ($bits(t_mid)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    cfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_crc_seed  (r_crc_seed),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_out),
        .o_mid_pop   (mid_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue
    cfc_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_empty (o_empty)
    );

    // result fields
    assign o_header_ok = res_out.header_ok;
    assign o_crc_ok    = res_out.crc_ok;
    assign o_action    = res_out.action;
    assign o_value_a   = $signed(res_out.values[0]);
    assign o_value_b   = $signed(res_out.values[1]);
    assign o_value_c   = $signed(res_out.values[2]);
    assign o_value_d   = $signed(res_out.values[3]);
    assign o_value_e   = $signed(res_out.values[4]);
    assign o_value_f   = $signed(res_out.values[5]);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the command frame checker: byte stream in, frame reports out
module tb;
    import cfc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 2;
    localparam int PHASE_FRAMES  = 3;
    localparam int STALL_FRAMES  = 6;

    // register indexes outside the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = '1;

    typedef enum {PACE_FLAT, PACE_SPARSE, PACE_BUSY} t_pace;

    // one predicted frame report, values[0] is value_a
    typedef struct packed {
        logic                        header_ok;
        logic                        crc_ok;
        t_action                     action;
        logic [NUM_VALUES-1:0][15:0] values;
    } t_frame_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    logic [7:0]            i_frame_byte;
    logic                  o_full;
    logic                  o_empty;
    logic                  i_pop;
    logic                  o_header_ok;
    logic                  o_crc_ok;
    logic [2:0]            o_action;
    logic signed [15:0]    o_value_a;
    logic signed [15:0]    o_value_b;
    logic signed [15:0]    o_value_c;
    logic signed [15:0]    o_value_d;
    logic signed [15:0]    o_value_e;
    logic signed [15:0]    o_value_f;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [15:0]           i_cfg_data;

    // predictor state and register copies
    logic [POS_W-1:0]            frame_pos;
    logic [15:0]                 crc_acc;
    logic                        hdr_match;
    logic [7:0]                  cmd_seen;
    logic [NUM_VALUES-1:0][15:0] value_regs;
    logic [7:0]                  crc_hi_seen;
    logic [7:0]                  cur_header;
    logic [15:0]                 cur_seed;

    t_frame_report pending_reports[$];
    logic [7:0]    frame_buf [FRAME_BYTES];
    string         value_names [NUM_VALUES] = '{"value_a", "value_b", "value_c",
                                                "value_d", "value_e", "value_f"};

    t_pace send_pace;
    t_pace recv_pace;
    int    hold_off_cycles;
    int    cycle_count;
    int    mismatches;
    int    bytes_sent;
    int    reports_seen;
    int    reg_writes;
    int    full_stall_cycles;
    int    action_hits [5];

    command_frame_checker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_frame_byte (i_frame_byte),
        .o_full       (o_full),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_header_ok  (o_header_ok),
        .o_crc_ok     (o_crc_ok),
        .o_action     (o_action),
        .o_value_a    (o_value_a),
        .o_value_b    (o_value_b),
        .o_value_c    (o_value_c),
        .o_value_d    (o_value_d),
        .o_value_e    (o_value_e),
        .o_value_f    (o_value_f),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d frame reports still outstanding",
                     $time, pending_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // crc-16 poly 0x1021, one data bit at a time, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic int draw_gap(input t_pace pace);
        case (pace)
            PACE_FLAT:   return 0;
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    // mostly random, with the signed extremes showing up often
    function automatic logic [NUM_VALUES-1:0][15:0] random_values();
        logic [NUM_VALUES-1:0][15:0] v;
        for (int i = 0; i < NUM_VALUES; i++) begin
            case ($urandom_range(0, 7))
                0:       v[i] = 16'h7FFF;
                1:       v[i] = 16'h8000;
                2:       v[i] = 16'h0000;
                3:       v[i] = 16'hFFFF;
                default: v[i] = 16'($urandom_range(0, 65535));
            endcase
        end
        return v;
    endfunction

    // predictor: absorb one accepted byte, queue a report on the last byte of a frame
    task automatic track_byte(input logic [7:0] b);
        t_frame_report rep;
        logic [2:0]    vi;
        if (frame_pos == HEAD_POS) begin
            hdr_match = (b == cur_header);
            crc_acc   = crc16_byte(cur_seed, b);
        end else if (frame_pos == CMD_POS) begin
            cmd_seen = b;
            crc_acc  = crc16_byte(crc_acc, b);
        end else if (frame_pos < CRC_END_POS) begin
            vi = 3'((frame_pos - VAL_POS) >> 1);
            if (!frame_pos[0]) value_regs[vi][15:8] = b;
            else               value_regs[vi][7:0]  = b;
            crc_acc = crc16_byte(crc_acc, b);
        end else if (frame_pos == CRC_END_POS) begin
            crc_hi_seen = b;
        end else begin
            rep.header_ok = hdr_match;
            rep.crc_ok    = ({crc_hi_seen, b} == crc_acc);
            // stop wins over a bad crc
            if (cmd_seen == CMD_STOP)   rep.action = ACT_STOP;
            else if (!rep.crc_ok)       rep.action = ACT_CRC_ERR;
            else if (cmd_seen == CMD_JOINT) rep.action = ACT_JOINT;
            else if (cmd_seen == CMD_POSE)  rep.action = ACT_POSE;
            else                        rep.action = ACT_UNKNOWN;
            rep.values = value_regs;
            pending_reports = {pending_reports, rep};
        end
        frame_pos = frame_pos + 1'b1;
    endtask

    // send one byte beat; push stays high on return so back-to-back beats need no gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(send_pace);
        repeat (gap) begin
            @(negedge i_clk);
            i_push = 1'b0;
        end
        @(negedge i_clk);
        i_push       = 1'b1;
        i_frame_byte = b;
        @(posedge i_clk);
        while (o_full) begin
            full_stall_cycles++;
            @(posedge i_clk);
        end
        track_byte(b);
        bytes_sent++;
    endtask

    // frame with crc over bytes 0..13 under the current seed, xored with fault
    task automatic build_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                               input logic [NUM_VALUES-1:0][15:0] vals,
                               input logic [15:0] fault);
        logic [15:0] c;
        frame_buf[0] = hdr;
        frame_buf[1] = cmd;
        for (int i = 0; i < NUM_VALUES; i++) begin
            frame_buf[2 + 2 * i] = vals[i][15:8];
            frame_buf[3 + 2 * i] = vals[i][7:0];
        end
        c = cur_seed;
        for (int i = 0; i < 14; i++) c = crc16_byte(c, frame_buf[i]);
        c = c ^ fault;
        frame_buf[14] = c[15:8];
        frame_buf[15] = c[7:0];
    endtask

    task automatic send_frame_part(input int first, input int last);
        for (int i = first; i <= last; i++) send_byte(frame_buf[i]);
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                              input logic [NUM_VALUES-1:0][15:0] vals,
                              input logic [15:0] fault);
        build_frame(hdr, cmd, vals, fault);
        send_frame_part(0, FRAME_BYTES - 1);
    endtask

    // stop offering bytes, let every report drain and the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_push = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_EXP_HEADER)    cur_header = data[7:0];
        else if (idx == CFG_CRC_SEED) cur_seed   = data;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic void compare_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // compare the report on the outputs with the oldest prediction
    task automatic check_report();
        t_frame_report               want;
        logic [NUM_VALUES-1:0][15:0] got;
        got = {o_value_f, o_value_e, o_value_d, o_value_c, o_value_b, o_value_a};
        if (pending_reports.size() == 0) begin
            $display("%0t ns: unexpected frame report, expected none, got action %0d",
                     $time, o_action);
            mismatches++;
        end else begin
            want = pending_reports.pop_front();
            compare_field("header_ok", want.header_ok, o_header_ok);
            compare_field("crc_ok", want.crc_ok, o_crc_ok);
            compare_field("action", want.action, o_action);
            for (int i = 0; i < NUM_VALUES; i++)
                compare_field(value_names[i], $signed(want.values[i]), $signed(got[i]));
            action_hits[want.action]++;
            reports_seen++;
        end
    endtask

    // report sink: random pop pacing, with an occasional long hold-off
    initial begin : report_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_cycles > 0) begin
                gap             = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                gap = draw_gap(recv_pace);
            end
            repeat (gap) begin
                @(negedge i_clk);
                i_pop = 1'b0;
            end
            @(negedge i_clk);
            i_pop = 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            check_report();
        end
    end

    // each command kind (joint, pose, stop, unknown) with good crc, value extremes
    task automatic check_command_kinds();
        send_pace = PACE_SPARSE;
        recv_pace = PACE_SPARSE;
        send_frame(cur_header, CMD_JOINT,
                   {16'h8001, 16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000}, 16'h0000);
        send_frame(cur_header, CMD_POSE, random_values(), 16'h0000);
        send_frame(cur_header, CMD_STOP, random_values(), 16'h0000);
        send_frame(cur_header, 8'h7E, random_values(), 16'h0000);
        wait_idle();
    endtask

    // bad crc: error for most commands, stop still acts
    task automatic check_crc_failures();
        send_pace = PACE_BUSY;
        recv_pace = PACE_BUSY;
        send_frame(cur_header, CMD_JOINT, random_values(), 16'h0100);
        send_frame(cur_header, CMD_POSE, random_values(), 16'h0001);
        send_frame(cur_header, CMD_STOP, random_values(), 16'h8000);
        send_frame(cur_header, 8'h42, random_values(), 16'hFFFF);
        wait_idle();
    endtask

    // wrong header only shows in header_ok
    task automatic check_header_mismatch();
        send_pace = PACE_FLAT;
        recv_pace = PACE_FLAT;
        send_frame(~cur_header, CMD_JOINT, random_values(), 16'h0000);
        send_frame(8'h00, CMD_POSE, random_values(), 16'h0000);
        wait_idle();
    endtask

    // register extremes and writes to indexes that do not exist
    task automatic check_register_settings();
        send_pace = PACE_SPARSE;
        recv_pace = PACE_SPARSE;
        write_register(CFG_SPARE_IDX, 16'h1234);
        write_register(CFG_TOP_IDX, 16'hFFFF);
        send_frame(cur_header, CMD_JOINT, random_values(), 16'h0000);
        wait_idle();
        write_register(CFG_EXP_HEADER, 16'h0000);
        write_register(CFG_CRC_SEED, 16'h0000);
        send_frame(8'h00, CMD_POSE, random_values(), 16'h0000);
        send_frame(8'hAA, CMD_JOINT, random_values(), 16'h0000);
        wait_idle();
        write_register(CFG_EXP_HEADER, 16'hFFFF);
        write_register(CFG_CRC_SEED, 16'h1D0F);
        send_frame(8'hFF, CMD_STOP, random_values(), 16'h0000);
        send_frame(8'hFF, 8'h80, random_values(), 16'h0000);
        wait_idle();
        write_register(CFG_EXP_HEADER, 16'(EXP_HEADER_RST));
        write_register(CFG_CRC_SEED, CRC_SEED_RST);
    endtask

    // a write in mid-frame only applies from the next frame on
    task automatic check_midframe_write();
        send_pace = PACE_SPARSE;
        recv_pace = PACE_FLAT;
        build_frame(cur_header, CMD_JOINT, random_values(), 16'h0000);
        send_frame_part(0, 6);
        wait_idle();
        write_register(CFG_EXP_HEADER, 16'h005A);
        write_register(CFG_CRC_SEED, 16'hC3A5);
        send_frame_part(7, FRAME_BYTES - 1);
        send_frame(8'h5A, CMD_POSE, random_values(), 16'h0000);
        wait_idle();
    endtask

    // sink holds off while bytes keep coming, so the block fills and stalls its input
    task automatic check_input_stall();
        send_pace       = PACE_FLAT;
        recv_pace       = PACE_FLAT;
        hold_off_cycles = LONG_HOLD;
        for (int f = 0; f < STALL_FRAMES; f++)
            send_frame(cur_header, CMD_JOINT, random_values(), 16'h0000);
        wait_idle();
    endtask

    // mostly well-formed frames with random content, some noise
    task automatic run_random_frames();
        logic [7:0]  hdr;
        logic [7:0]  cmd;
        logic [15:0] fault;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            if ($urandom_range(0, 1) == 0)
                write_register(CFG_EXP_HEADER, 16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 1) == 0)
                write_register(CFG_CRC_SEED, 16'($urandom_range(0, 65535)));
            send_pace = t_pace'($urandom_range(0, 2));
            recv_pace = t_pace'($urandom_range(0, 2));
            for (int f = 0; f < PHASE_FRAMES; f++) begin
                if ($urandom_range(0, 4) == 0) begin
                    for (int i = 0; i < FRAME_BYTES; i++)
                        frame_buf[i] = 8'($urandom_range(0, 255));
                    send_frame_part(0, FRAME_BYTES - 1);
                end else begin
                    hdr = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : cur_header;
                    case ($urandom_range(0, 4))
                        0:       cmd = CMD_JOINT;
                        1:       cmd = CMD_POSE;
                        2:       cmd = CMD_STOP;
                        default: cmd = 8'($urandom_range(0, 255));
                    endcase
                    fault = ($urandom_range(0, 3) == 0) ?
                            16'($urandom_range(1, 65535)) : 16'h0000;
                    send_frame(hdr, cmd, random_values(), fault);
                end
            end
        end
        wait_idle();
    endtask

    // stimulus
    initial begin
        i_rst_n      = 1'b0;
        i_push       = 1'b0;
        i_pop        = 1'b0;
        i_frame_byte = 8'h00;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = 16'h0000;
        cur_header   = EXP_HEADER_RST;
        cur_seed     = CRC_SEED_RST;
        frame_pos    = HEAD_POS;
        crc_acc      = CRC_SEED_RST;
        hdr_match    = 1'b0;
        cmd_seen     = 8'h00;
        value_regs   = '0;
        crc_hi_seen  = 8'h00;
        send_pace    = PACE_FLAT;
        recv_pace    = PACE_FLAT;
        hold_off_cycles   = 0;
        cycle_count       = 0;
        mismatches        = 0;
        bytes_sent        = 0;
        reports_seen      = 0;
        reg_writes        = 0;
        full_stall_cycles = 0;
        foreach (action_hits[i]) action_hits[i] = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_command_kinds();
        check_crc_failures();
        check_header_mismatch();
        check_register_settings();
        check_midframe_write();
        check_input_stall();
        run_random_frames();

        wait_idle();
        $display("%0d bytes sent, %0d frame reports checked, %0d register writes",
                 bytes_sent, reports_seen, reg_writes);
        $display("%0d stalled input cycles; actions: crc error %0d, joint %0d, pose %0d, %s",
                 full_stall_cycles, action_hits[ACT_CRC_ERR], action_hits[ACT_JOINT],
                 action_hits[ACT_POSE],
                 $sformatf("stop %0d, unknown %0d", action_hits[ACT_STOP],
                           action_hits[ACT_UNKNOWN]));
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/cfc_pkg.sv
sv/cfc_fifo.sv
sv/cfc_front.sv
sv/cfc_back.sv
sv/command_frame_checker.sv
verif/tb.sv
